### design/running_median_two_heaps_top_assert.svh
// Assertion macros for the running median block.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_TOP_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_TOP_ASSERT_SVH
// Implication checked every clock edge outside reset.
`define RM_ASSERT_IMP(lbl, c, a, e) \
  lbl: assert property (@(posedge clk) disable iff (rst) (c) |-> (a)) else $error(e);
// Next-cycle implication checked outside reset.
`define RM_ASSERT_NEXT(lbl, c, a, e) \
  lbl: assert property (@(posedge clk) disable iff (rst) (c) |=> (a)) else $error(e);
`endif

### design/rmth_pkg.sv
// Package for the running median block: sizes, types and sequencer states.
package rmth_pkg;
  localparam int Capacity = 4096;
  localparam int DataWidth = 32;
  localparam int LowerDepth = (Capacity + 1) / 2;
  localparam int UpperDepth = Capacity / 2;
  localparam int AddrW = $clog2(LowerDepth);
  localparam int SizeW = $clog2(LowerDepth + 1);
  localparam int CountW = $clog2(Capacity + 1);
  localparam int PosW = 13;

  typedef logic [DataWidth-1:0] key_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [SizeW-1:0] size_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INS_WR, ST_UP_RD, ST_UP_WAIT, ST_UP_CMP,
    ST_TOP_RD, ST_TOP_WAIT, ST_TOP_CMP,
    ST_DN_RD_L, ST_DN_RD_R, ST_DN_WAIT, ST_DN_CMP, ST_DN_SW,
    ST_OUT_RD, ST_OUT_WAIT, ST_EMIT
  } state_t;

  // Port of one heap memory driven by the sequencer.
  typedef struct packed {
    logic  we;
    addr_t addr;
    key_t  wdata;
  } mem_req_t;
endpackage

### design/rmth_ram.sv
// Generic single-port RAM with registered read.
module rmth_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### design/rmth_seq.sv
// Sequencer that inserts, sifts and reads the two heaps.
module rmth_seq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_go,
  input  logic                    start_req,
  input  rmth_pkg::key_t          key_in,
  output logic                    busy,
  output logic                    res_go,
  output rmth_pkg::key_t          res_key,
  output logic [rmth_pkg::PosW-1:0] res_pos,
  output logic                    res_drop,
  output rmth_pkg::mem_req_t      lo_req,
  output rmth_pkg::mem_req_t      up_req,
  input  rmth_pkg::key_t          lo_rdata,
  input  rmth_pkg::key_t          up_rdata
);
  rmth_pkg::state_t state, state_next;
  rmth_pkg::size_t lower_size, lower_size_next, upper_size, upper_size_next;
  logic [rmth_pkg::CountW-1:0] count, count_next;
  logic side, side_next;          // 0: lower (max) heap, 1: upper (min) heap
  logic dn_second, dn_second_next; // the pending result word is a dropped one
  rmth_pkg::addr_t pos, pos_next, par, kid, kid_next;
  rmth_pkg::key_t cur, cur_next, oth, oth_next, lk, lk_next;
  logic [rmth_pkg::AddrW:0] lidx, ridx;
  rmth_pkg::size_t hsize;
  rmth_pkg::key_t rd;
  logic above;

  assign rd = side ? up_rdata : lo_rdata;
  assign hsize = side ? upper_size : lower_size;
  assign par = rmth_pkg::AddrW'((pos - 1'b1) >> 1);
  assign lidx = {pos, 1'b1};
  assign ridx = lidx + 1'b1;

  // The sift-down compare unit: does rd belong above oth in this heap?
  assign above = side ? (rd < oth) : (rd > oth);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmth_pkg::ST_IDLE;
      lower_size <= '0;
      upper_size <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      lower_size <= lower_size_next;
      upper_size <= upper_size_next;
      count <= count_next;
    end
    side <= side_next;
    dn_second <= dn_second_next;
    pos <= pos_next;
    kid <= kid_next;
    cur <= cur_next;
    oth <= oth_next;
    lk <= lk_next;
  end

  always_comb begin
    state_next = state;
    lower_size_next = lower_size;
    upper_size_next = upper_size;
    count_next = count;
    side_next = side;
    dn_second_next = dn_second;
    pos_next = pos;
    kid_next = kid;
    cur_next = cur;
    oth_next = oth;
    lk_next = lk;
    lo_req = '0;
    up_req = '0;
    busy = 1'b1;
    res_go = 1'b0;
    res_drop = 1'b0;
    case (state)
      rmth_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (in_go) begin
          if (start_req) begin
            lower_size_next = '0;
            upper_size_next = '0;
            count_next = '0;
          end
          cur_next = key_in;
          if (!start_req && count >= rmth_pkg::CountW'(rmth_pkg::Capacity)) begin
            state_next = rmth_pkg::ST_EMIT;
            dn_second_next = 1'b1;
          end else begin
            dn_second_next = 1'b0;
            side_next = start_req ? 1'b0 : (lower_size != upper_size);
            pos_next = start_req ? '0 :
                       rmth_pkg::AddrW'((lower_size != upper_size) ? upper_size : lower_size);
            state_next = rmth_pkg::ST_INS_WR;
          end
        end
      end
      rmth_pkg::ST_INS_WR: begin
        if (side) begin
          up_req = '{we: 1'b1, addr: pos, wdata: cur};
          upper_size_next = upper_size + 1'b1;
        end else begin
          lo_req = '{we: 1'b1, addr: pos, wdata: cur};
          lower_size_next = lower_size + 1'b1;
        end
        count_next = count + 1'b1;
        state_next = (pos == '0) ? rmth_pkg::ST_TOP_RD : rmth_pkg::ST_UP_RD;
      end
      rmth_pkg::ST_UP_RD: begin
        // cur holds the rising key at pos; fetch its parent.
        if (side) up_req.addr = par; else lo_req.addr = par;
        state_next = rmth_pkg::ST_UP_WAIT;
      end
      rmth_pkg::ST_UP_WAIT: begin
        // Hold the parent address so that the read register still shows it.
        if (side) up_req.addr = par; else lo_req.addr = par;
        oth_next = cur;
        state_next = rmth_pkg::ST_UP_CMP;
      end
      rmth_pkg::ST_UP_CMP: begin
        // rd is the parent; cur moves up while the parent does not sit above it.
        if (side ? (cur < rd) : (cur > rd)) begin
          if (side) up_req = '{we: 1'b1, addr: pos, wdata: rd};
          else lo_req = '{we: 1'b1, addr: pos, wdata: rd};
          pos_next = par;
          state_next = (par == '0) ? rmth_pkg::ST_TOP_RD : rmth_pkg::ST_UP_RD;
          if (par == '0) begin
            // Write the new key at the root on the way out.
            state_next = rmth_pkg::ST_TOP_RD;
          end
        end else begin
          state_next = rmth_pkg::ST_TOP_RD;
        end
        oth_next = rd;
      end
      rmth_pkg::ST_TOP_RD: begin
        // Place the rising key at its final slot, then read both roots.
        if (side) up_req = '{we: 1'b1, addr: pos, wdata: cur};
        else lo_req = '{we: 1'b1, addr: pos, wdata: cur};
        state_next = rmth_pkg::ST_TOP_WAIT;
      end
      rmth_pkg::ST_TOP_WAIT: begin
        lo_req.addr = '0;
        up_req.addr = '0;
        state_next = rmth_pkg::ST_TOP_CMP;
      end
      rmth_pkg::ST_TOP_CMP: begin
        if (lower_size != '0 && upper_size != '0 && lo_rdata > up_rdata) begin
          lo_req = '{we: 1'b1, addr: '0, wdata: up_rdata};
          up_req = '{we: 1'b1, addr: '0, wdata: lo_rdata};
          side_next = 1'b0;
          pos_next = '0;
          cur_next = up_rdata;
          lk_next = lo_rdata;
          state_next = rmth_pkg::ST_DN_RD_L;
        end else begin
          lk_next = lo_rdata;
          state_next = count[0] ? rmth_pkg::ST_EMIT : rmth_pkg::ST_IDLE;
        end
      end
      rmth_pkg::ST_DN_RD_L: begin
        // cur is the sinking key at pos.
        if (lidx >= (rmth_pkg::AddrW+1)'(hsize)) begin
          if (!side) begin
            side_next = 1'b1;
            pos_next = '0;
            cur_next = lk;
            state_next = rmth_pkg::ST_DN_RD_L;
          end else begin
            state_next = rmth_pkg::ST_OUT_RD;
          end
        end else begin
          if (side) up_req.addr = rmth_pkg::AddrW'(lidx);
          else lo_req.addr = rmth_pkg::AddrW'(lidx);
          oth_next = cur;
          kid_next = pos;
          state_next = rmth_pkg::ST_DN_RD_R;
        end
      end
      rmth_pkg::ST_DN_RD_R: begin
        if (side) up_req.addr = rmth_pkg::AddrW'(ridx);
        else lo_req.addr = rmth_pkg::AddrW'(ridx);
        // Left child data arrives now.
        if (above) begin
          oth_next = rd;
          kid_next = rmth_pkg::AddrW'(lidx);
        end
        state_next = rmth_pkg::ST_DN_WAIT;
      end
      rmth_pkg::ST_DN_WAIT: begin
        if (ridx < (rmth_pkg::AddrW+1)'(hsize) && above) begin
          oth_next = rd;
          kid_next = rmth_pkg::AddrW'(ridx);
        end
        state_next = rmth_pkg::ST_DN_CMP;
      end
      rmth_pkg::ST_DN_CMP: begin
        if (kid == pos) begin
          if (!side) begin
            side_next = 1'b1;
            pos_next = '0;
            cur_next = lk;
            state_next = rmth_pkg::ST_DN_RD_L;
          end else begin
            state_next = rmth_pkg::ST_OUT_RD;
          end
        end else begin
          if (side) up_req = '{we: 1'b1, addr: pos, wdata: oth};
          else lo_req = '{we: 1'b1, addr: pos, wdata: oth};
          state_next = rmth_pkg::ST_DN_SW;
        end
      end
      rmth_pkg::ST_DN_SW: begin
        if (side) up_req = '{we: 1'b1, addr: kid, wdata: cur};
        else lo_req = '{we: 1'b1, addr: kid, wdata: cur};
        pos_next = kid;
        state_next = rmth_pkg::ST_DN_RD_L;
      end
      rmth_pkg::ST_OUT_RD: begin
        state_next = count[0] ? rmth_pkg::ST_OUT_WAIT : rmth_pkg::ST_IDLE;
      end
      rmth_pkg::ST_OUT_WAIT: begin
        lo_req.addr = '0;
        lk_next = lo_rdata;
        state_next = rmth_pkg::ST_EMIT;
      end
      rmth_pkg::ST_EMIT: begin
        res_go = 1'b1;
        res_drop = dn_second;
        state_next = rmth_pkg::ST_IDLE;
      end
      default: state_next = rmth_pkg::ST_IDLE;
    endcase
  end

  assign res_key = lk;
  assign res_pos = rmth_pkg::PosW'(count);
endmodule

### design/running_median_two_heaps_top.sv
// Top level of the running median block: heaps, sequencer and output register.
// One input word is taken when the block is idle and the output register is
// empty; it is written into the lower (max) or upper (min) heap and sifted up,
// the two roots are compared and, when out of order, swapped and both heaps
// sifted down. Each heap holds 2048 entries; the time an item takes is set by
// the single-port heap memories, which the sequencer walks level by level. After
// each odd-numbered value a result word with the median and the count is placed
// in an output register; when 4096 values are held, a new value is dropped and a
// result word with dropped set and median zero is given. A start request clears
// the sequence.
`include "running_median_two_heaps_top_assert.svh"
module running_median_two_heaps_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       start_req,
  input  logic signed [31:0]         value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         median,
  output logic [12:0]                position,
  output logic                       dropped
);
  logic busy, res_go, res_drop, in_go;
  rmth_pkg::key_t res_key, lo_rdata, up_rdata, key_in;
  logic [rmth_pkg::PosW-1:0] res_pos;
  rmth_pkg::mem_req_t lo_req, up_req;

  // Keys are stored with the sign bit flipped so that unsigned order is signed order.
  assign key_in = {~value[31], value[30:0]};

  // A new word waits until the previous result has left the output register.
  assign in_stall = busy || out_valid;
  assign in_go = in_valid && !in_stall;

  rmth_ram #(.Width(rmth_pkg::DataWidth), .Depth(rmth_pkg::LowerDepth)) u_lower (
    .clk(clk), .we(lo_req.we), .addr(lo_req.addr), .wdata(lo_req.wdata), .rdata(lo_rdata)
  );
  rmth_ram #(.Width(rmth_pkg::DataWidth), .Depth(rmth_pkg::UpperDepth)) u_upper (
    .clk(clk), .we(up_req.we), .addr(up_req.addr), .wdata(up_req.wdata), .rdata(up_rdata)
  );

  rmth_seq u_seq (
    .clk(clk), .rst(rst), .in_go(in_go), .start_req(start_req), .key_in(key_in),
    .busy(busy), .res_go(res_go), .res_key(res_key), .res_pos(res_pos),
    .res_drop(res_drop), .lo_req(lo_req), .up_req(up_req),
    .lo_rdata(lo_rdata), .up_rdata(up_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_go) begin
      median <= res_drop ? '0 : {~res_key[31], res_key[30:0]};
      position <= res_pos;
      dropped <= res_drop;
    end
  end

  `RM_ASSERT_IMP(a_no_accept_busy, busy, !in_go, "input accepted while busy")
  `RM_ASSERT_IMP(a_res_when_free, res_go, !out_valid, "result overwrote pending word")
  `RM_ASSERT_NEXT(a_drop_zero, res_go && res_drop, median == 0, "dropped word with median")
endmodule
